// File: hdl/brkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_pkg
// Shared constants and types of the C source bracket matcher.
// ----------------------------------------------------------------------------
package brkm_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int LINE_WIDTH_DEF  = 16;

   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;

   localparam logic [2:0] ST_ECHO       = 3'd0;
   localparam logic [2:0] ST_BAD_PAREN  = 3'd1;
   localparam logic [2:0] ST_BAD_BRACE  = 3'd2;
   localparam logic [2:0] ST_BALANCED   = 3'd3;
   localparam logic [2:0] ST_OPEN_PAREN = 3'd4;
   localparam logic [2:0] ST_OPEN_BRACE = 3'd5;
   localparam logic [2:0] ST_OVERFLOW   = 3'd6;

   // region flag bits, one means "not inside"
   localparam int FLAG_LINE  = 0;
   localparam int FLAG_BLOCK = 1;
   localparam int FLAG_STR   = 2;
   localparam int FLAG_CHR   = 3;
   localparam logic [3:0] FLAGS_ALL = 4'hF;

   typedef struct packed {
      logic is_open;
      logic is_close;
      logic is_brace;
      logic last;
   } brkm_op_type;

endpackage

// File: hdl/brkm_ifaces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_ifaces
// Valid/ready channels for source bytes and matcher results.
// ----------------------------------------------------------------------------
interface brkm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_text;

   modport source (output valid, output byte_in, output end_of_text, input ready);
   modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface brkm_rsp_if #(
   parameter int LINE_WIDTH = brkm_pkg::LINE_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic [2:0]            status;
   logic [7:0]            bracket;
   logic [LINE_WIDTH-1:0] line;
   logic                  final_res;

   modport source (output valid, output status, output bracket, output line,
                   output final_res, input ready);
   modport sink   (input valid, input status, input bracket, input line,
                   input final_res, output ready);
endinterface

// File: hdl/brkm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brkm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = brkm_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/brkm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_fifo
// Small register FIFO that decouples the classifier from the stack engine.
// ----------------------------------------------------------------------------
module brkm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));

endmodule

// File: hdl/brkm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_front
// Accepts source bytes, tracks comment and literal regions and the line
// count, and forwards bracket and end-of-file operations.
// ----------------------------------------------------------------------------
module brkm_front #(
   parameter int LINE_WIDTH = brkm_pkg::LINE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   brkm_req_if.sink              req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output brkm_pkg::brkm_op_type q_op,
   output logic [LINE_WIDTH-1:0] q_line
);

   logic [7:0]            prior_ff, prior_in;
   logic [3:0]            flags_ff, flags_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic [7:0]            b;
   logic [3:0]            flags_nx;
   logic                  outside;
   logic                  accept;

   assign b      = req_chan.byte_in;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !q_full;

   always_comb begin
      flags_nx = flags_ff;
      if (prior_ff == brkm_pkg::CH_SLASH && b == brkm_pkg::CH_SLASH) begin
         flags_nx[brkm_pkg::FLAG_LINE] = 1'b0;
      end else if (prior_ff == brkm_pkg::CH_SLASH && b == brkm_pkg::CH_STAR) begin
         flags_nx[brkm_pkg::FLAG_BLOCK] = 1'b0;
      end else if (prior_ff == brkm_pkg::CH_STAR && b == brkm_pkg::CH_SLASH) begin
         flags_nx[brkm_pkg::FLAG_BLOCK] = 1'b1;
      end else if (b == brkm_pkg::CH_NEWLINE) begin
         flags_nx[brkm_pkg::FLAG_LINE] = 1'b1;
      end else if (b == brkm_pkg::CH_DQUOTE) begin
         flags_nx[brkm_pkg::FLAG_STR] = !flags_ff[brkm_pkg::FLAG_STR];
      end else if (b == brkm_pkg::CH_SQUOTE && flags_ff[brkm_pkg::FLAG_STR]) begin
         flags_nx[brkm_pkg::FLAG_CHR] = !flags_ff[brkm_pkg::FLAG_CHR];
      end
   end

   assign outside = (flags_nx == brkm_pkg::FLAGS_ALL);

   always_comb begin
      q_op.is_open  = outside && (b == brkm_pkg::CH_LPAREN || b == brkm_pkg::CH_LBRACE);
      q_op.is_close = outside && (b == brkm_pkg::CH_RPAREN || b == brkm_pkg::CH_RBRACE);
      q_op.is_brace = (b == brkm_pkg::CH_LBRACE || b == brkm_pkg::CH_RBRACE);
      q_op.last     = req_chan.end_of_text;
   end

   // brackets never share a beat with a newline, so the current line is exact
   assign q_line = line_ff;
   assign q_push = accept && (q_op.is_open || q_op.is_close || q_op.last);

   always_comb begin
      prior_in = prior_ff;
      flags_in = flags_ff;
      line_in  = line_ff;
      if (accept) begin
         if (req_chan.end_of_text) begin
            prior_in = '0;
            flags_in = brkm_pkg::FLAGS_ALL;
            line_in  = LINE_WIDTH'(1);
         end else begin
            prior_in = b;
            flags_in = flags_nx;
            if (b == brkm_pkg::CH_NEWLINE && line_ff != {LINE_WIDTH{1'b1}}) begin
               line_in = line_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         flags_ff <= brkm_pkg::FLAGS_ALL;
         line_ff  <= LINE_WIDTH'(1);
      end else begin
         prior_ff <= prior_in;
         flags_ff <= flags_in;
         line_ff  <= line_in;
      end
   end

endmodule

// File: hdl/brkm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_back
// Stack engine: pushes and pops bracket kinds, detects mismatch and
// overflow, and drives the result register. The two top entries live in
// flops; deeper entries are in RAM with the next one prefetched.
// ----------------------------------------------------------------------------
module brkm_back #(
   parameter int STACK_DEPTH = brkm_pkg::STACK_DEPTH_DEF,
   parameter int LINE_WIDTH  = brkm_pkg::LINE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  brkm_pkg::brkm_op_type q_op,
   input  logic [LINE_WIDTH-1:0] q_line,
   output logic                  q_pop,
   brkm_rsp_if.source            rsp_chan
);

   localparam int TW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [TW-1:0]         top_ff, top_in;
   logic                  k1_ff, k1_in;
   logic                  k2_ff, k2_in;
   logic [LINE_WIDTH-1:0] outer_ff, outer_in;
   logic                  halted_ff, halted_in;
   logic                  halt_now;

   logic                  out_valid_ff, out_valid_in;
   logic [2:0]            out_status_ff, out_status_in;
   logic [7:0]            out_bracket_ff, out_bracket_in;
   logic [LINE_WIDTH-1:0] out_line_ff, out_line_in;
   logic                  out_final_ff, out_final_in;

   logic                  pend_valid_ff, pend_valid_in;
   logic [2:0]            pend_status_ff, pend_status_in;
   logic [LINE_WIDTH-1:0] pend_line_ff, pend_line_in;

   logic                  r1_valid;
   logic [2:0]            r1_status;
   logic [7:0]            r1_bracket;
   logic [LINE_WIDTH-1:0] r1_line;
   logic                  r1_final;
   logic                  fin_valid;
   logic [2:0]            fin_status;
   logic [LINE_WIDTH-1:0] fin_line;

   logic                  out_free;
   logic                  wr_en;
   logic [TW-1:0]         rd_ptr;
   logic                  rd_kind;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign q_pop    = q_valid && out_free && !pend_valid_ff;

   always_comb begin
      top_in     = top_ff;
      k1_in      = k1_ff;
      k2_in      = k2_ff;
      outer_in   = outer_ff;
      halted_in  = halted_ff;
      halt_now   = 1'b0;
      wr_en      = 1'b0;
      r1_valid   = 1'b0;
      r1_status  = brkm_pkg::ST_ECHO;
      r1_bracket = '0;
      r1_line    = '0;
      r1_final   = 1'b0;
      fin_valid  = 1'b0;
      fin_status = brkm_pkg::ST_BALANCED;
      fin_line   = '0;
      if (q_pop) begin
         if (!halted_ff && q_op.is_open) begin
            r1_valid = 1'b1;
            if (top_ff >= TW'(STACK_DEPTH)) begin
               r1_status = brkm_pkg::ST_OVERFLOW;
               r1_line   = q_line;
               r1_final  = 1'b1;
               halt_now  = 1'b1;
            end else begin
               wr_en      = 1'b1;
               k2_in      = k1_ff;
               k1_in      = q_op.is_brace;
               top_in     = top_ff + 1'b1;
               r1_bracket = q_op.is_brace ? brkm_pkg::CH_LBRACE : brkm_pkg::CH_LPAREN;
               if (top_ff == '0) begin
                  outer_in = q_line;
               end
            end
         end else if (!halted_ff && q_op.is_close) begin
            r1_valid = 1'b1;
            if (top_ff != '0 && k1_ff == q_op.is_brace) begin
               top_in     = top_ff - 1'b1;
               k1_in      = k2_ff;
               k2_in      = rd_kind;
               r1_bracket = q_op.is_brace ? brkm_pkg::CH_RBRACE : brkm_pkg::CH_RPAREN;
            end else begin
               r1_status = q_op.is_brace ? brkm_pkg::ST_BAD_BRACE : brkm_pkg::ST_BAD_PAREN;
               r1_line   = q_line;
               r1_final  = 1'b1;
               halt_now  = 1'b1;
            end
         end
         if (halt_now) begin
            halted_in = 1'b1;
         end
         if (q_op.last) begin
            if (!halted_ff && !halt_now) begin
               fin_valid = 1'b1;
               if (top_in == '0) begin
                  fin_status = brkm_pkg::ST_BALANCED;
               end else begin
                  fin_status = k1_in ? brkm_pkg::ST_OPEN_BRACE : brkm_pkg::ST_OPEN_PAREN;
                  fin_line   = outer_in;
               end
            end
            top_in    = '0;
            outer_in  = '0;
            halted_in = 1'b0;
         end
      end
   end

   // prefetch the entry that sits third from the top after this beat
   assign rd_ptr = top_in - TW'(3);

   brkm_ram #(
      .WIDTH (1),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (top_ff[AW-1:0]),
      .wr_data (q_op.is_brace),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rd_kind)
   );

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_bracket_in = out_bracket_ff;
      out_line_in    = out_line_ff;
      out_final_in   = out_final_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_line_in   = pend_line_ff;
      if (q_pop) begin
         out_valid_in = r1_valid || fin_valid;
         if (r1_valid) begin
            out_status_in  = r1_status;
            out_bracket_in = r1_bracket;
            out_line_in    = r1_line;
            out_final_in   = r1_final;
            pend_valid_in  = fin_valid;
            pend_status_in = fin_status;
            pend_line_in   = fin_line;
         end else begin
            out_status_in  = fin_status;
            out_bracket_in = '0;
            out_line_in    = fin_line;
            out_final_in   = 1'b1;
         end
      end else if (pend_valid_ff && out_free) begin
         out_valid_in   = 1'b1;
         out_status_in  = pend_status_ff;
         out_bracket_in = '0;
         out_line_in    = pend_line_ff;
         out_final_in   = 1'b1;
         pend_valid_in  = 1'b0;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff        <= '0;
         outer_ff      <= '0;
         halted_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         top_ff        <= top_in;
         outer_ff      <= outer_in;
         halted_ff     <= halted_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff          <= k1_in;
      k2_ff          <= k2_in;
      out_status_ff  <= out_status_in;
      out_bracket_ff <= out_bracket_in;
      out_line_ff    <= out_line_in;
      out_final_ff   <= out_final_in;
      pend_status_ff <= pend_status_in;
      pend_line_ff   <= pend_line_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.bracket   = out_bracket_ff;
   assign rsp_chan.line      = out_line_ff;
   assign rsp_chan.final_res = out_final_ff;

endmodule

// File: hdl/bracket_matcher_c_source.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_matcher_c_source
// Checks bracket balance of C source text streamed one byte per beat.
// ----------------------------------------------------------------------------
// req_chan carries one source byte per beat; end_of_text marks the last byte
// of a file. rsp_chan returns an echo beat for every '(' '{' ')' '}' seen
// outside comments and literals, an error beat (bad close or overflow) that
// stops checking for the rest of the file, and at the last byte a closing
// beat: balanced, or the kind of the innermost open bracket with the line of
// the outermost one. final_res marks the last beat of each file.
// Throughput is one byte per cycle while rsp_chan accepts; a last byte that
// also yields an echo sends its closing beat from a pending register, which
// holds off the queue meanwhile. A result reaches rsp_chan through the
// classifier-to-stack queue and then the stack engine, which updates the top
// two cached entries and the RAM per cycle and registers the result.
// When rsp_chan stalls, the two-entry queue fills and req_chan.ready drops;
// bytes keep flowing as long as the queue has room.
// Reset is synchronous and clears the queue, the stack pointer, the region
// flags and sets the line counter to one. The stack RAM needs no clearing.
// ----------------------------------------------------------------------------
module bracket_matcher_c_source #(
   parameter int STACK_DEPTH = brkm_pkg::STACK_DEPTH_DEF,
   parameter int LINE_WIDTH  = brkm_pkg::LINE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   brkm_req_if.sink   req_chan,
   brkm_rsp_if.source rsp_chan
);

   localparam int QW = $bits(brkm_pkg::brkm_op_type) + LINE_WIDTH;

   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_valid;
   brkm_pkg::brkm_op_type front_op;
   logic [LINE_WIDTH-1:0] front_line;
   brkm_pkg::brkm_op_type back_op;
   logic [LINE_WIDTH-1:0] back_line;
   logic [QW-1:0]         q_rd_data;

   brkm_front #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_op     (front_op),
      .q_line   (front_line)
   );

   brkm_fifo #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_op, front_line}),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .not_empty (q_valid),
      .full      (q_full)
   );

   assign back_op   = brkm_pkg::brkm_op_type'(q_rd_data[QW-1:LINE_WIDTH]);
   assign back_line = q_rd_data[LINE_WIDTH-1:0];

   brkm_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .LINE_WIDTH  (LINE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_op     (back_op),
      .q_line   (back_line),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hdl/brkm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkm_checker
// Port-level checks on the result channel of the bracket matcher.
// ----------------------------------------------------------------------------
module brkm_checker #(
   parameter int LINE_WIDTH = brkm_pkg::LINE_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [2:0]            rsp_status,
   input logic [7:0]            rsp_bracket,
   input logic [LINE_WIDTH-1:0] rsp_line,
   input logic                  rsp_final
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_echo_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brkm_pkg::ST_ECHO |->
         !rsp_final && rsp_line == '0 &&
         (rsp_bracket == brkm_pkg::CH_LPAREN || rsp_bracket == brkm_pkg::CH_RPAREN ||
          rsp_bracket == brkm_pkg::CH_LBRACE || rsp_bracket == brkm_pkg::CH_RBRACE))
      else $error("malformed echo beat");

   a_closing_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != brkm_pkg::ST_ECHO |-> rsp_final && rsp_bracket == '0)
      else $error("closing or error beat without final flag");

   a_balanced_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brkm_pkg::ST_BALANCED |-> rsp_line == '0)
      else $error("balanced beat carries a line");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_line))
      else $error("stalled result changed");

endmodule

bind bracket_matcher_c_source brkm_checker #(
   .LINE_WIDTH (LINE_WIDTH)
) u_brkm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_bracket (rsp_chan.bracket),
   .rsp_line    (rsp_chan.line),
   .rsp_final   (rsp_chan.final_res)
);
